>>> sv/hufd_pkg.sv
package hufd_pkg;

  // Default sizes of the node memory, the code length limit and the symbol width.
  localparam int MAX_NODES_DEF    = 512;
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int SYMBOL_BITS_DEF  = 8;

  // Item kinds carried on in_tuser.
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_TABLE  = 2'd1;
  localparam logic [1:0] KIND_DECODE = 2'd2;

  // Result status codes carried on out_tuser.
  localparam logic [2:0] ST_SYMBOL  = 3'd0;
  localparam logic [2:0] ST_CLEARED = 3'd1;
  localparam logic [2:0] ST_ADDED   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BADPATH = 3'd4;
  localparam logic [2:0] ST_MIDCODE = 3'd5;

  // One result on its way to the output stage.
  typedef struct packed {
    logic [7:0] symbol;
    logic [2:0] status;
  } res_t;

endpackage

>>> sv/huffman_tree_decoder_core.sv
// Huffman tree decoder: a code tree in a node memory, walked one code bit per step.
// A clear item empties the tree and hands its result on through S_FIN; a table entry
// walks its code path, reading each existing node and allocating each missing one.
// A decode byte reads the node memory, a registered read, for each valid bit it walks
// and emits each symbol found; a new item is taken only back in S_IDLE.
// Reset (rst_n low, synchronous): empty tree, walk at the root, no results pending.
module huffman_tree_decoder_core
  import hufd_pkg::*;
#(
  parameter int MAX_NODES    = MAX_NODES_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int SYMBOL_BITS  = SYMBOL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] table_symbol, [12:8] code_length, [28:13] code_value,
  // [36:29] data_byte, [40:37] valid_bits, [47:41] zero
  input  logic [47:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  // end_of_stream
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] symbol
  output logic [7:0]  out_tdata,
  // [2:0] status
  output logic [2:0]  out_tuser,
  // last result of the input transaction
  output logic        out_tlast
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int NODE_W = 2 * IDX_W + SYMBOL_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FIN    = 4'd1;
  localparam logic [3:0] S_T_STEP = 4'd2;
  localparam logic [3:0] S_T_WAIT = 4'd3;
  localparam logic [3:0] S_T_END  = 4'd4;
  localparam logic [3:0] S_D_LOAD = 4'd5;
  localparam logic [3:0] S_D_FTCH = 4'd6;
  localparam logic [3:0] S_D_WAIT = 4'd7;
  localparam logic [3:0] S_D_EMIT = 4'd8;
  localparam logic [3:0] S_D_TAIL = 4'd9;

  // Input transaction fields.
  logic [7:0]  f_sym;
  logic [4:0]  f_len;
  logic [15:0] f_code;
  logic [7:0]  f_byte;
  logic [3:0]  f_vbits;
  logic        accept;

  assign f_sym   = in_tdata[7:0];
  assign f_len   = in_tdata[12:8];
  assign f_code  = in_tdata[28:13];
  assign f_byte  = in_tdata[36:29];
  assign f_vbits = in_tdata[40:37];
  assign accept  = in_tvalid && in_tready;

  // Control state.
  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;      // walk position, 0 is the root
  logic [IDX_W:0]   nfree_r, nfree_nxt;  // next node to allocate
  // The root lives in flip-flops so that reset and clear empty the tree at once;
  // entries 1 and up live in the node memory.
  logic [IDX_W-1:0]       root_l_r, root_l_nxt;
  logic [IDX_W-1:0]       root_r_r, root_r_nxt;
  logic [SYMBOL_BITS-1:0] root_s_r, root_s_nxt;

  // Working copy of the node under the walk, and the serial operands.
  logic [IDX_W-1:0]       nl_r, nl_nxt;
  logic [IDX_W-1:0]       nr_r, nr_nxt;
  logic [SYMBOL_BITS-1:0] ns_r, ns_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic [4:0]             cnt_r, cnt_nxt;   // code bits or stream bits still to walk
  logic [31:0]            code_r, code_nxt;
  logic [7:0]             byte_r, byte_nxt; // stream byte, MSB leaves first
  logic                   eos_r, eos_nxt;

  // Node memory port.
  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_addr;
  logic [NODE_W-1:0]      ram_wdata, ram_rdata;
  logic [IDX_W-1:0]       rd_l, rd_r;
  logic [SYMBOL_BITS-1:0] rd_s;

  // Write-back of the working node to the root or the node memory.
  logic                   do_wb;
  logic [IDX_W-1:0]       wb_l, wb_r;
  logic [SYMBOL_BITS-1:0] wb_s;

  // Result stage.
  logic       push, fin, res_ready;
  res_t       push_res;
  logic [15:0] ns_ext;

  logic             bit_c;
  logic [IDX_W-1:0] child;
  logic             tree_full;
  logic             bad_len;

  assign {rd_l, rd_r, rd_s} = ram_rdata;
  assign ns_ext    = 16'(ns_r);
  assign tree_full = (nfree_r == (IDX_W+1)'(MAX_NODES));
  assign bad_len   = (f_len == 5'd0) || (32'(f_len) > MAX_CODE_LEN);
  assign in_tready = (state_r == S_IDLE);

  // The bit that picks the next child: a code bit chosen by the down counter for
  // table entries, the top of the stream shift register for decoding.
  always_comb begin
    if (state_r == S_T_STEP) begin
      bit_c = code_r[5'(cnt_r - 5'd1)];
    end else begin
      bit_c = byte_r[7];
    end
    child = bit_c ? nr_r : nl_r;
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    nfree_nxt  = nfree_r;
    root_l_nxt = root_l_r;
    root_r_nxt = root_r_r;
    root_s_nxt = root_s_r;
    nl_nxt     = nl_r;
    nr_nxt     = nr_r;
    ns_nxt     = ns_r;
    sym_nxt    = sym_r;
    cnt_nxt    = cnt_r;
    code_nxt   = code_r;
    byte_nxt   = byte_r;
    eos_nxt    = eos_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = idx_r;
    do_wb      = 1'b0;
    wb_l       = nl_r;
    wb_r       = nr_r;
    wb_s       = ns_r;
    push       = 1'b0;
    push_res   = '{symbol: 8'd0, status: ST_SYMBOL};
    fin        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_tuser)
            KIND_CLEAR: begin
              root_l_nxt = '0;
              root_r_nxt = '0;
              root_s_nxt = '0;
              nfree_nxt  = (IDX_W+1)'(1);
              idx_nxt    = '0;
              push       = 1'b1;
              push_res   = '{symbol: 8'd0, status: ST_CLEARED};
              state_nxt  = S_FIN;
            end
            KIND_TABLE: begin
              idx_nxt = '0;
              if (bad_len) begin
                push      = 1'b1;
                push_res  = '{symbol: 8'd0, status: ST_BADPATH};
                state_nxt = S_FIN;
              end else begin
                nl_nxt    = root_l_r;
                nr_nxt    = root_r_r;
                ns_nxt    = root_s_r;
                cnt_nxt   = f_len;
                code_nxt  = 32'(f_code);
                sym_nxt   = SYMBOL_BITS'(f_sym);
                state_nxt = S_T_STEP;
              end
            end
            KIND_DECODE: begin
              byte_nxt = f_byte;
              cnt_nxt  = (f_vbits > 4'd8) ? 5'd8 : 5'(f_vbits);
              eos_nxt  = in_tlast;
              if (idx_r == '0) begin
                nl_nxt    = root_l_r;
                nr_nxt    = root_r_r;
                ns_nxt    = root_s_r;
                state_nxt = S_D_FTCH;
              end else begin
                // A code left open by the previous byte resumes from memory.
                ram_re    = 1'b1;
                state_nxt = S_D_LOAD;
              end
            end
            default: begin
              // Undefined kind: the transaction is taken and ignored.
            end
          endcase
        end
      end

      S_T_STEP: begin
        if (cnt_r == 5'd0) begin
          state_nxt = S_T_END;
        end else if (child == '0) begin
          // Every step that meets a missing child writes the working node back,
          // which also stores a freshly allocated node for the first time.
          do_wb = 1'b1;
          if (tree_full) begin
            push      = 1'b1;
            push_res  = '{symbol: 8'd0, status: ST_FULL};
            idx_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            if (bit_c) begin
              wb_r = nfree_r[IDX_W-1:0];
            end else begin
              wb_l = nfree_r[IDX_W-1:0];
            end
            nl_nxt    = '0;
            nr_nxt    = '0;
            ns_nxt    = '0;
            idx_nxt   = nfree_r[IDX_W-1:0];
            nfree_nxt = nfree_r + (IDX_W+1)'(1);
            cnt_nxt   = cnt_r - 5'd1;
          end
        end else begin
          ram_re    = 1'b1;
          ram_addr  = child;
          idx_nxt   = child;
          cnt_nxt   = cnt_r - 5'd1;
          state_nxt = S_T_WAIT;
        end
      end

      S_T_WAIT: begin
        nl_nxt    = rd_l;
        nr_nxt    = rd_r;
        ns_nxt    = rd_s;
        state_nxt = S_T_STEP;
      end

      S_T_END: begin
        do_wb     = 1'b1;
        wb_s      = sym_r;
        push      = 1'b1;
        push_res  = '{symbol: 8'd0, status: ST_ADDED};
        idx_nxt   = '0;
        state_nxt = S_FIN;
      end

      S_D_LOAD: begin
        nl_nxt    = rd_l;
        nr_nxt    = rd_r;
        ns_nxt    = rd_s;
        state_nxt = S_D_FTCH;
      end

      S_D_FTCH: begin
        if (cnt_r == 5'd0) begin
          state_nxt = S_D_TAIL;
        end else if (child == '0) begin
          // Missing child: report it and drop the rest of the byte.
          if (res_ready) begin
            push      = 1'b1;
            push_res  = '{symbol: 8'd0, status: ST_BADPATH};
            idx_nxt   = '0;
            state_nxt = S_FIN;
          end
        end else begin
          ram_re    = 1'b1;
          ram_addr  = child;
          idx_nxt   = child;
          byte_nxt  = {byte_r[6:0], 1'b0};
          cnt_nxt   = cnt_r - 5'd1;
          state_nxt = S_D_WAIT;
        end
      end

      S_D_WAIT: begin
        nl_nxt = rd_l;
        nr_nxt = rd_r;
        ns_nxt = rd_s;
        if (rd_l == '0 && rd_r == '0) begin
          state_nxt = S_D_EMIT;
        end else begin
          state_nxt = S_D_FTCH;
        end
      end

      S_D_EMIT: begin
        if (res_ready) begin
          push      = 1'b1;
          push_res  = '{symbol: ns_ext[7:0], status: ST_SYMBOL};
          idx_nxt   = '0;
          nl_nxt    = root_l_r;
          nr_nxt    = root_r_r;
          ns_nxt    = root_s_r;
          state_nxt = S_D_FTCH;
        end
      end

      S_D_TAIL: begin
        if (eos_r && idx_r != '0) begin
          if (res_ready) begin
            push      = 1'b1;
            push_res  = '{symbol: 8'd0, status: ST_MIDCODE};
            idx_nxt   = '0;
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // Release the held result with its last flag set.
        fin = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_wb) begin
      if (idx_r == '0) begin
        root_l_nxt = wb_l;
        root_r_nxt = wb_r;
        root_s_nxt = wb_s;
      end else begin
        ram_we = 1'b1;
      end
    end
    ram_wdata = {wb_l, wb_r, wb_s};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      nfree_r  <= (IDX_W+1)'(1);
      root_l_r <= '0;
      root_r_r <= '0;
      root_s_r <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      nfree_r  <= nfree_nxt;
      root_l_r <= root_l_nxt;
      root_r_r <= root_r_nxt;
      root_s_r <= root_s_nxt;
    end
    nl_r   <= nl_nxt;
    nr_r   <= nr_nxt;
    ns_r   <= ns_nxt;
    sym_r  <= sym_nxt;
    cnt_r  <= cnt_nxt;
    code_r <= code_nxt;
    byte_r <= byte_nxt;
    eos_r  <= eos_nxt;
  end

  hufd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  hufd_res_buf u_res_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_res_i (push_res),
    .fin_i      (fin),
    .ready_o    (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sv/hufd_ram.sv
module hufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/hufd_res_buf.sv
module hufd_res_buf
  import hufd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  res_t       push_res_i,
  input  logic       fin_i,
  output logic       ready_o,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [2:0] out_tuser,
  output logic       out_tlast
);

  // The newest result is held back one step so that its last flag is known
  // when it moves on to the output register.
  logic pend_v_r, pend_v_nxt;
  res_t pend_r, pend_nxt;
  logic out_v_r, out_v_nxt;
  res_t out_r, out_nxt;
  logic last_r, last_nxt;
  logic out_free;

  assign out_free = !out_v_r || out_tready;
  assign ready_o  = !pend_v_r || out_free;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_nxt    = out_r;
    last_nxt   = last_r;
    if (push_i && ready_o) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = pend_r;
        last_nxt  = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = push_res_i;
    end else if (fin_i && ready_o && pend_v_r) begin
      out_v_nxt  = 1'b1;
      out_nxt    = pend_r;
      last_nxt   = 1'b1;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.symbol;
  assign out_tuser  = out_r.status;
  assign out_tlast  = last_r;

endmodule
